// ===== rtl/core/smbi_pkg.sv =====
// Shared types and constants of the scattered-map bilinear interpolator.
package smbi_pkg;

  localparam int THR_W = 15;
  localparam int RPM_W = 14;
  localparam int DLY_W = 16;
  localparam int IDX_W = 6;
  localparam int CFG_W = 7;
  localparam int STS_W = 2;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY   = 2'd1;
  localparam logic [STS_W-1:0] STS_OUTSIDE = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // One stored map cell.
  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [RPM_W-1:0] rpm;
    logic [DLY_W-1:0] dly;
  } smbi_cell_t;

  // A classified item as handed from the front part to the back part.
  typedef struct packed {
    logic             is_query;
    logic             write_ok;
    logic [IDX_W-1:0] cell_index;
    logic [THR_W-1:0] thr;
    logic [RPM_W-1:0] rpm;
    logic [DLY_W-1:0] dly;
  } smbi_item_t;

endpackage

// ===== rtl/core/smbi_req_if.sv =====
// Request channel: one cell write or one query per transfer.
interface smbi_req_if;
  import smbi_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] cell_index;
  logic [THR_W-1:0] cell_throttle;
  logic [RPM_W-1:0] cell_rpm;
  logic [DLY_W-1:0] cell_delay;
  logic [THR_W-1:0] query_throttle;
  logic [RPM_W-1:0] query_rpm;

  modport source (output valid, req_type, cell_index, cell_throttle, cell_rpm, cell_delay,
                  query_throttle, query_rpm, input ready);
  modport sink (input valid, req_type, cell_index, cell_throttle, cell_rpm, cell_delay,
                query_throttle, query_rpm, output ready);
endinterface

// ===== rtl/core/smbi_rsp_if.sv =====
// Response channel: one result per request.
interface smbi_rsp_if;
  import smbi_pkg::*;
  logic             valid;
  logic             ready;
  logic [DLY_W-1:0] injection_delay;
  logic [STS_W-1:0] status;

  modport source (output valid, injection_delay, status, input ready);
  modport sink (input valid, injection_delay, status, output ready);
endinterface

// ===== rtl/core/smbi_cfg_if.sv =====
// Configuration write channel for the cells-in-use register.
interface smbi_cfg_if;
  import smbi_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] cells_in_use;

  modport source (output valid, cells_in_use, input ready);
  modport sink (input valid, cells_in_use, output ready);
endinterface

// ===== rtl/core/smbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/smbi_front.sv =====
// Front part: accepts requests, classifies them and queues them for the back part.
module smbi_front import smbi_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  smbi_req_if.sink   req,
  output logic       item_valid,
  input  logic       item_ready,
  output smbi_item_t item
);

  smbi_item_t  queue [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  smbi_item_t  cls;

  // Classify the incoming request into the common item form.
  always_comb begin
    cls.is_query   = (req.req_type == REQ_QUERY);
    cls.write_ok   = (32'(req.cell_index) < MAX_CELLS);
    cls.cell_index = req.cell_index;
    cls.thr        = cls.is_query ? req.query_throttle : req.cell_throttle;
    cls.rpm        = cls.is_query ? req.query_rpm : req.cell_rpm;
    cls.dly        = req.cell_delay;
  end

  assign req.ready  = (count != 2'd2);
  assign push       = req.valid && req.ready;
  assign item_valid = (count != 2'd0);
  assign pop        = item_valid && item_ready;
  assign item       = queue[rptr];

  // Two-entry queue between the front and back parts.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= cls;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/smbi_back.sv =====
// Back part: cell writes, the two bracketing scans, blending and the serial divide.
module smbi_back import smbi_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] cells_in_use,
  input  logic             item_valid,
  output logic             item_ready,
  input  smbi_item_t       item,
  smbi_rsp_if.source       rsp
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;
  localparam int PW = DLY_W + THR_W;
  localparam int MW = PW + RPM_W;
  localparam int SW = MW + 2;
  localparam int DW = THR_W + RPM_W;
  localparam int RW = DW + 1;
  localparam int KW = $clog2(SW);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN1, S_CHECK, S_SCAN2, S_SPAN, S_MULA, S_MULB, S_DEN, S_DIV, S_DONE
  } state_t;

  state_t           state;
  logic [THR_W-1:0] q_thr;
  logic [RPM_W-1:0] q_rpm;
  logic [CW-1:0]    n;
  logic [CW-1:0]    cnt;
  logic             rd_vld;
  logic             rd_first;
  logic [THR_W-1:0] tl, th;
  logic [RPM_W-1:0] rl, rh;
  logic             has_tl, has_th, has_rl, has_rh;
  logic [DLY_W-1:0] d00, d10, d01, d11;
  logic [THR_W-1:0] ax, bx, dx;
  logic [RPM_W-1:0] ay, by, dy;
  logic [1:0]       k;
  logic [PW-1:0]    prod;
  logic [SW-1:0]    acc;
  logic [DW-1:0]    den;
  logic [RW-1:0]    rem;
  logic [KW-1:0]    dcnt;
  logic             out_valid;
  logic [DLY_W-1:0] out_delay;
  logic [STS_W-1:0] out_status;

  logic [NW-1:0]    cfg_w;
  logic [CW-1:0]    n_eff;
  logic             pop;
  logic             issue;
  smbi_cell_t       wcell;
  smbi_cell_t       c;
  logic [DLY_W-1:0] d_sel;
  logic [THR_W-1:0] wx_sel;
  logic [RPM_W-1:0] wy_sel;
  logic [MW-1:0]    mterm;
  logic [RW-1:0]    trial;
  logic             qbit;
  logic             lo_t, hi_t, lo_r, hi_r;

  // Cells scanned by a query, clamped to the store depth.
  assign cfg_w = NW'(cells_in_use);
  assign n_eff = (cfg_w > NW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cfg_w);

  assign pop        = item_valid && (state == S_IDLE) && !out_valid;
  assign item_ready = pop;
  assign issue      = ((state == S_SCAN1) || (state == S_SCAN2)) && (cnt < n);

  assign wcell.thr = item.thr;
  assign wcell.rpm = item.rpm;
  assign wcell.dly = item.dly;

  smbi_ram #(
    .WIDTH ($bits(smbi_cell_t)),
    .DEPTH (MAX_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (pop && !item.is_query && item.write_ok),
    .waddr (AW'(item.cell_index)),
    .wdata (wcell),
    .raddr (cnt[AW-1:0]),
    .rdata (c)
  );

  // Bracket tests of the cell being read in the second scan.
  assign lo_t = (c.thr <= q_thr) && (c.thr >= tl);
  assign hi_t = (c.thr >= q_thr) && (c.thr <= th);
  assign lo_r = (c.rpm <= q_rpm) && (c.rpm >= rl);
  assign hi_r = (c.rpm >= q_rpm) && (c.rpm <= rh);

  // Corner operand selection for the shared multiplier.
  always_comb begin
    case (k)
      2'd0: begin d_sel = d00; wx_sel = bx; wy_sel = by; end
      2'd1: begin d_sel = d10; wx_sel = ax; wy_sel = by; end
      2'd2: begin d_sel = d01; wx_sel = bx; wy_sel = ay; end
      2'd3: begin d_sel = d11; wx_sel = ax; wy_sel = ay; end
      default: begin d_sel = d00; wx_sel = bx; wy_sel = by; end
    endcase
  end

  assign mterm = prod * wy_sel;

  // One restoring divide step per cycle.
  assign trial = {rem[RW-2:0], acc[SW-1]};
  assign qbit  = (trial >= RW'(den));

  // Sequencer with its datapath registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      rd_first  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld   <= issue;
      rd_first <= issue && (cnt == '0);
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            q_thr <= item.thr;
            q_rpm <= item.rpm;
            n     <= n_eff;
            cnt   <= '0;
            has_tl <= 1'b0;
            has_th <= 1'b0;
            has_rl <= 1'b0;
            has_rh <= 1'b0;
            if (!item.is_query) begin
              out_valid  <= 1'b1;
              out_delay  <= '0;
              out_status <= STS_OK;
            end else if (n_eff == '0) begin
              out_valid  <= 1'b1;
              out_delay  <= '0;
              out_status <= STS_EMPTY;
            end else begin
              state <= S_SCAN1;
            end
          end
        end
        S_SCAN1: begin
          if (rd_vld) begin
            if ((c.thr <= q_thr) && (!has_tl || (c.thr >= tl))) begin
              tl <= c.thr; has_tl <= 1'b1;
            end
            if ((c.thr >= q_thr) && (!has_th || (c.thr <= th))) begin
              th <= c.thr; has_th <= 1'b1;
            end
            if ((c.rpm <= q_rpm) && (!has_rl || (c.rpm >= rl))) begin
              rl <= c.rpm; has_rl <= 1'b1;
            end
            if ((c.rpm >= q_rpm) && (!has_rh || (c.rpm <= rh))) begin
              rh <= c.rpm; has_rh <= 1'b1;
            end
          end
          if (!issue && !rd_vld) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt <= '0;
          if (has_tl && has_th && has_rl && has_rh) begin
            state <= S_SCAN2;
          end else begin
            out_valid  <= 1'b1;
            out_delay  <= '0;
            out_status <= STS_OUTSIDE;
            state      <= S_IDLE;
          end
        end
        S_SCAN2: begin
          if (rd_vld) begin
            // Cell 0 is the default corner; a later match replaces it.
            if (rd_first) begin
              d00 <= c.dly; d10 <= c.dly; d01 <= c.dly; d11 <= c.dly;
            end
            if (lo_t && lo_r) d00 <= c.dly;
            if (hi_t && lo_r) d10 <= c.dly;
            if (lo_t && hi_r) d01 <= c.dly;
            if (hi_t && hi_r) d11 <= c.dly;
          end
          if (!issue && !rd_vld) begin
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          // A zero span gives the low corner full weight.
          if (th == tl) begin
            dx <= THR_W'(1); ax <= '0; bx <= THR_W'(1);
          end else begin
            dx <= th - tl; ax <= q_thr - tl; bx <= th - q_thr;
          end
          if (rh == rl) begin
            dy <= RPM_W'(1); ay <= '0; by <= RPM_W'(1);
          end else begin
            dy <= rh - rl; ay <= q_rpm - rl; by <= rh - q_rpm;
          end
          k     <= 2'd0;
          acc   <= '0;
          state <= S_MULA;
        end
        S_MULA: begin
          prod  <= d_sel * wx_sel;
          state <= S_MULB;
        end
        S_MULB: begin
          acc <= acc + SW'(mterm);
          k   <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_DEN;
          end else begin
            state <= S_MULA;
          end
        end
        S_DEN: begin
          den   <= dx * dy;
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= qbit ? (trial - RW'(den)) : trial;
          acc  <= {acc[SW-2:0], qbit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == KW'(SW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid  <= 1'b1;
          out_delay  <= (|acc[SW-1:DLY_W]) ? {DLY_W{1'b1}} : acc[DLY_W-1:0];
          out_status <= STS_OK;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.injection_delay = out_delay;
  assign rsp.status          = out_status;

  // The divider never runs with a zero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0))
    else $error("divide started with zero denominator");

  // Read data is only flagged valid after an address was issued in a scan.
  a_rd_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> ($past(state) == S_SCAN1 || $past(state) == S_SCAN2))
    else $error("read data valid outside a scan");

  // Error and empty results carry a zero delay.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != STS_OK)) |-> (out_delay == '0))
    else $error("error result with non-zero delay");

  // No new item is taken while a result waits in the output register.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !item_ready)
    else $error("item taken while result pending");

endmodule

// ===== rtl/core/scattered_map_bilinear_interpolator_core.sv =====
// Top level of the scattered-map bilinear interpolator.
//
// Usage: the req channel carries either a cell write (req_type 0), which stores
// throttle, rpm and delay at cell_index, or a query (req_type 1), which returns
// the bilinear blend of the four map cells that bracket the query point. Every
// request gives exactly one transfer on the rsp channel, in request order. The
// cfg channel writes the cells_in_use register; it is always ready and must only
// be used while no request is outstanding.
// Requests enter a two-entry queue, so up to two may be taken while a result is
// held. A query over N scanned cells makes two passes over the cell store through
// its single read port, four shared multiply steps and a one-bit-per-cycle 47-bit
// divide. Only one item is worked on at a time in the back part.
// Reset (synchronous, active high) empties the queue, clears the result register
// and sets cells_in_use to 0; cell contents stay undefined until written.
// When the receiver stalls, the result is held in the output register and the
// back part waits; the queue keeps taking requests until it is full.
module scattered_map_bilinear_interpolator_core import smbi_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic     clk,
  input  logic     rst,
  smbi_req_if.sink req,
  smbi_rsp_if.source rsp,
  smbi_cfg_if.sink cfg
);

  logic             cells_in_use;
  logic [CFG_W-1:0] cells_reg;
  logic             item_valid;
  logic             item_ready;
  smbi_item_t       item;

  // Configuration register.
  assign cfg.ready    = 1'b1;
  assign cells_in_use = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_reg <= '0;
    end else if (cells_in_use) begin
      cells_reg <= cfg.cells_in_use;
    end
  end

  smbi_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  smbi_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cells_in_use (cells_reg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .rsp          (rsp)
  );

endmodule

// ===== dv/tb_scattered_map_bilinear_interpolator_core.sv =====
// Self-checking testbench for the scattered-map bilinear interpolator core.
`timescale 1ns / 1ps

module tb_scattered_map_bilinear_interpolator_core;
  import smbi_pkg::*;

  localparam int NCELLS     = 64;
  localparam int LIMIT      = 3000000;
  localparam int ITEM_GOAL  = 1550;
  localparam int END_CYCLES = 300;

  typedef struct packed {
    logic [DLY_W-1:0] dly;
    logic [STS_W-1:0] sts;
  } delay_result_t;

  logic clk;
  logic rst;

  smbi_req_if req_ch ();
  smbi_rsp_if rsp_ch ();
  smbi_cfg_if cfg_ch ();

  scattered_map_bilinear_interpolator_core #(.MAX_CELLS(NCELLS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Mirror of the map store and the scan length.
  logic [THR_W-1:0] map_thr [NCELLS];
  logic [RPM_W-1:0] map_rpm [NCELLS];
  logic [DLY_W-1:0] map_dly [NCELLS];
  int unsigned      scan_len;

  delay_result_t pending_delays [$];
  int  errors;
  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  ok_results;
  int  empty_results;
  int  outside_results;
  longint cycles;
  bit  send_idle;
  bit  recv_idle;
  int  recv_hold;

  // Expected result of one accepted request; a write also updates the mirror.
  function automatic delay_result_t interp_predict(
      logic rt, logic [IDX_W-1:0] ci, logic [THR_W-1:0] ct, logic [RPM_W-1:0] cr,
      logic [DLY_W-1:0] cd, logic [THR_W-1:0] qt, logic [RPM_W-1:0] qr);
    delay_result_t r;
    int unsigned n;
    bit htl, hth, hrl, hrh;
    int unsigned tl, th, rl, rh;
    int unsigned c00, c10, c01, c11;
    bit lt, ht, lr, hr;
    longint unsigned dx, dy, ax, bx, ay, by, sum, res;
    r = '0;
    htl = 0; hth = 0; hrl = 0; hrh = 0;
    tl = 0; th = 0; rl = 0; rh = 0;
    c00 = 0; c10 = 0; c01 = 0; c11 = 0;
    if (rt == REQ_WRITE) begin
      map_thr[ci] = ct;
      map_rpm[ci] = cr;
      map_dly[ci] = cd;
      r.sts = STS_OK;
      return r;
    end
    n = (scan_len > NCELLS) ? NCELLS : scan_len;
    if (n == 0) begin
      r.sts = STS_EMPTY;
      return r;
    end
    // First pass: nearest bounds on each axis.
    for (int i = 0; i < n; i++) begin
      if (map_thr[i] <= qt && (!htl || map_thr[i] >= tl)) begin tl = map_thr[i]; htl = 1; end
      if (map_thr[i] >= qt && (!hth || map_thr[i] <= th)) begin th = map_thr[i]; hth = 1; end
      if (map_rpm[i] <= qr && (!hrl || map_rpm[i] >= rl)) begin rl = map_rpm[i]; hrl = 1; end
      if (map_rpm[i] >= qr && (!hrh || map_rpm[i] <= rh)) begin rh = map_rpm[i]; hrh = 1; end
    end
    if (!(htl && hth && hrl && hrh)) begin
      r.sts = STS_OUTSIDE;
      return r;
    end
    // Second pass: corner cells, the last match winning.
    for (int i = 0; i < n; i++) begin
      lt = map_thr[i] <= qt && map_thr[i] >= tl;
      ht = map_thr[i] >= qt && map_thr[i] <= th;
      lr = map_rpm[i] <= qr && map_rpm[i] >= rl;
      hr = map_rpm[i] >= qr && map_rpm[i] <= rh;
      if (lt && lr) c00 = i;
      if (ht && lr) c10 = i;
      if (lt && hr) c01 = i;
      if (ht && hr) c11 = i;
    end
    dx = th - tl; ax = qt - tl; bx = th - qt;
    if (dx == 0) begin dx = 1; ax = 0; bx = 1; end
    dy = rh - rl; ay = qr - rl; by = rh - qr;
    if (dy == 0) begin dy = 1; ay = 0; by = 1; end
    sum = longint'(map_dly[c00]) * bx * by + longint'(map_dly[c10]) * ax * by
        + longint'(map_dly[c01]) * bx * ay + longint'(map_dly[c11]) * ax * ay;
    res = sum / (dx * dy);
    if (res > 65535) res = 65535;
    r.dly = res[DLY_W-1:0];
    r.sts = STS_OK;
    return r;
  endfunction

  // Clock and the single reset at the start.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Cycle counter with a timeout.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycles, pending_delays.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Predict on every request transfer and track register writes.
  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) scan_len = cfg_ch.cells_in_use;
    if (!rst && req_ch.valid && req_ch.ready)
      pending_delays.push_back(interp_predict(req_ch.req_type, req_ch.cell_index,
          req_ch.cell_throttle, req_ch.cell_rpm, req_ch.cell_delay,
          req_ch.query_throttle, req_ch.query_rpm));
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    delay_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_delays.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("Unexpected result: delay %0d status %0d",
                   rsp_ch.injection_delay, rsp_ch.status);
      end else begin
        exp_r = pending_delays.pop_front();
        case (exp_r.sts)
          STS_OK:    ok_results++;
          STS_EMPTY: empty_results++;
          default:   outside_results++;
        endcase
        if (rsp_ch.injection_delay !== exp_r.dly || rsp_ch.status !== exp_r.sts) begin
          errors++;
          if (mismatches++ < 10)
            $display("Mismatch at result %0d: expected delay %0d status %0d, got %0d %0d",
                     results_seen, exp_r.dly, exp_r.sts, rsp_ch.injection_delay,
                     rsp_ch.status);
        end
      end
    end
  end

  // Receiver: random idle bursts and an occasional long hold-off.
  initial begin
    int gap;
    gap = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        recv_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Send one request, waiting for its transfer.
  task automatic send_req(logic rt, logic [IDX_W-1:0] ci, logic [THR_W-1:0] ct,
                          logic [RPM_W-1:0] cr, logic [DLY_W-1:0] cd,
                          logic [THR_W-1:0] qt, logic [RPM_W-1:0] qr);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= rt;
    req_ch.cell_index     <= ci;
    req_ch.cell_throttle  <= ct;
    req_ch.cell_rpm       <= cr;
    req_ch.cell_delay     <= cd;
    req_ch.query_throttle <= qt;
    req_ch.query_rpm      <= qr;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic write_cell(int idx, int t, int r, int d);
    send_req(REQ_WRITE, IDX_W'(idx), THR_W'(t), RPM_W'(r), DLY_W'(d),
             THR_W'($urandom), RPM_W'($urandom));
  endtask

  task automatic query_at(int t, int r);
    send_req(REQ_QUERY, IDX_W'($urandom), THR_W'($urandom), RPM_W'($urandom),
             DLY_W'($urandom), THR_W'(t), RPM_W'(r));
  endtask

  // Let every outstanding result arrive, then write the scan length.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_delays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_scan_len(int v);
    wait_drained();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.cells_in_use <= CFG_W'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Directed: empty table, a 2x2 grid at throttle 0 and 25600 and the rpm extremes, edge queries.
  task automatic test_directed();
    query_at(100, 100);
    write_cell(0, 0, 0, 0);
    write_cell(1, 25600, 0, 65535);
    write_cell(2, 0, 16383, 65535);
    write_cell(3, 25600, 16383, 65535);
    set_scan_len(4);
    query_at(0, 0);
    query_at(25600, 16383);
    query_at(12800, 8191);
    query_at(25599, 16382);
    query_at(1, 1);
    query_at(0, 16383);
    query_at(32767, 100);
    query_at(100, 0);
    // Degenerate spans: all cells on one throttle line.
    write_cell(1, 0, 0, 1000);
    write_cell(3, 0, 16383, 3);
    query_at(0, 5000);
    query_at(5, 5000);
    set_scan_len(0);
    query_at(0, 0);
  endtask

  // Random maps of varying size, mostly queried inside their extent.
  task automatic run_phase(int n, int nq);
    int tmin, tmax, rmin, rmax, t, r, sel, lv_t[4], lv_r[4];
    for (int k = 0; k < 4; k++) begin
      lv_t[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                           : $urandom_range(0, 25600);
      lv_r[k] = $urandom_range(0, 16383);
    end
    for (int i = 0; i < n; i++)
      write_cell(i, lv_t[$urandom_range(0, 3)], lv_r[$urandom_range(0, 3)], $urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) set_scan_len(0);
    else if (n == NCELLS && sel < 4) set_scan_len($urandom_range(65, 127));
    else set_scan_len(n);
    tmin = 32767; tmax = 0; rmin = 16383; rmax = 0;
    for (int i = 0; i < n; i++) begin
      if (map_thr[i] < tmin) tmin = map_thr[i];
      if (map_thr[i] > tmax) tmax = map_thr[i];
      if (map_rpm[i] < rmin) rmin = map_rpm[i];
      if (map_rpm[i] > rmax) rmax = map_rpm[i];
    end
    for (int q = 0; q < nq; q++) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) begin
        t = $urandom_range(tmin, tmax);
        r = $urandom_range(rmin, rmax);
        query_at(t, r);
      end else if (sel < 17) begin
        sel = $urandom_range(0, n - 1);
        query_at(map_thr[sel], map_rpm[$urandom_range(0, n - 1)]);
      end else if (sel < 19) begin
        query_at($urandom_range(0, 32767), $urandom_range(0, 16383));
      end else begin
        // Overwrite a scanned slot in the middle of the query stream.
        write_cell($urandom_range(0, n - 1), lv_t[$urandom_range(0, 3)],
                   lv_r[$urandom_range(0, 3)], $urandom);
        tmin = 0; tmax = 32767; rmin = 0; rmax = 16383;
        for (int i = 0; i < n; i++) begin
          if (map_thr[i] > tmin) tmin = map_thr[i];
          if (map_thr[i] < tmax) tmax = map_thr[i];
          if (map_rpm[i] > rmin) rmin = map_rpm[i];
          if (map_rpm[i] < rmax) rmax = map_rpm[i];
        end
        t = tmin; tmin = tmax; tmax = t;
        r = rmin; rmin = rmax; rmax = r;
      end
    end
  endtask

  task automatic test_random();
    int n;
    while (items_sent < ITEM_GOAL - 150) begin
      n = ($urandom_range(0, 9) == 0) ? NCELLS : $urandom_range(1, 8);
      run_phase(n, $urandom_range(10, 30));
    end
  endtask

  // Hold the receiver off while writes keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_drained();
    recv_hold = 400;
    for (int i = 0; i < 12; i++)
      write_cell($urandom_range(0, 63), $urandom, $urandom, $urandom);
    run_phase(4, 10);
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_full_rate();
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    while (items_sent < ITEM_GOAL)
      run_phase($urandom_range(1, 8), 20);
  endtask

  initial begin
    int waited;
    errors = 0; mismatches = 0; items_sent = 0; results_seen = 0;
    ok_results = 0; empty_results = 0; outside_results = 0;
    scan_len = 0; recv_hold = 0; send_idle = 1; recv_idle = 1;
    for (int i = 0; i < NCELLS; i++) begin
      map_thr[i] = '0; map_rpm[i] = '0; map_dly[i] = '0;
    end
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_WRITE;
    req_ch.cell_index <= '0;
    req_ch.cell_throttle <= '0;
    req_ch.cell_rpm <= '0;
    req_ch.cell_delay <= '0;
    req_ch.query_throttle <= '0;
    req_ch.query_rpm <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.cells_in_use <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();
    test_full_rate();

    req_ch.valid <= 1'b0;
    while (pending_delays.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < END_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    $display("Sent %0d requests; results: %0d ok, %0d empty table, %0d outside table.",
             items_sent, ok_results, empty_results, outside_results);
    $display("Map sizes 1 to 64 cells, scan lengths 0 to 127, %0d errors.", errors);
    if (errors == 0 && pending_delays.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
